>>> src/line_pixel_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Line pixel rasterizer assertion macros
// Shorthand for clocked assertions that are disabled while reset is applied.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_RASTERIZER_ASSERT_SVH
`define LINE_PIXEL_RASTERIZER_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define LPR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line_pixel_rasterizer assertion failed");

// The antecedent implies the consequent in the next cycle.
`define LPR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line_pixel_rasterizer assertion failed");

`endif

>>> src/lpr_pkg.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer package
// Command codes and fixed sizing shared by the rasterizer modules.
// ----------------------------------------------------------------------------
package lpr_pkg;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } lpr_cmd_e;

  // The decision variable is two bits wider than a coordinate.
  localparam int unsigned ErrExtraBits = 2;

endpackage

>>> src/lpr_cmd_if.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer command channel
// Valid/ready channel that carries start and advance commands.
// ----------------------------------------------------------------------------
interface lpr_cmd_if #(
  parameter int unsigned COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, output cmd, output x_start, output y_start,
                  output x_end, output y_end, input ready);
  modport sink   (input valid, input cmd, input x_start, input y_start,
                  input x_end, input y_end, output ready);
endinterface

>>> src/lpr_pix_if.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer pixel channel
// Valid/ready channel that carries emitted line pixels.
// ----------------------------------------------------------------------------
interface lpr_pix_if #(
  parameter int unsigned COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                  output ready);
endinterface

>>> src/lpr_engine.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer engine
// Holds the line state and computes the next pixel for one command per cycle while fire_i is high.
// ----------------------------------------------------------------------------
module lpr_engine import lpr_pkg::*; #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic                  cmd_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic                  res_valid_o,
  output logic [COORD_BITS-1:0] res_x_o,
  output logic [COORD_BITS-1:0] res_y_o,
  output logic                  res_last_o,
  output logic                  busy_o
);

  localparam int unsigned W = COORD_BITS;
  localparam int unsigned E = COORD_BITS + ErrExtraBits;

  logic [W-1:0]        cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [W-1:0]        stop_x_q, stop_x_d, stop_y_q, stop_y_d;
  logic signed [E-1:0] err_q, err_d, inc_s_q, inc_s_d, inc_d_q, inc_d_d;
  logic                maj_x_q, maj_x_d, busy_q, busy_d;

  logic                is_start;
  logic signed [W:0]   dx, dy;
  logic [W:0]          adx_w, ady_w;
  logic [W-1:0]        adx, ady, dmaj, dmin;
  logic signed [E-1:0] ext_maj, ext_min;
  logic                maj_x_s, swap;
  logic [W-1:0]        sx0, sy0, sx1, sy1;

  assign is_start = (lpr_cmd_e'(cmd_i) == CMD_START);

  always_comb begin
    dx      = $signed({1'b0, x_end_i}) - $signed({1'b0, x_start_i});
    dy      = $signed({1'b0, y_end_i}) - $signed({1'b0, y_start_i});
    adx_w   = dx[W] ? (W+1)'(0) - dx : dx;
    ady_w   = dy[W] ? (W+1)'(0) - dy : dy;
    adx     = adx_w[W-1:0];
    ady     = ady_w[W-1:0];
    maj_x_s = (adx >= ady);
    dmaj    = maj_x_s ? adx : ady;
    dmin    = maj_x_s ? ady : adx;
    swap    = maj_x_s ? !(x_start_i < x_end_i) : !(y_start_i < y_end_i);
    sx0     = swap ? x_end_i : x_start_i;
    sy0     = swap ? y_end_i : y_start_i;
    sx1     = swap ? x_start_i : x_end_i;
    sy1     = swap ? y_start_i : y_end_i;
    ext_maj = $signed({{ErrExtraBits{1'b0}}, dmaj});
    ext_min = $signed({{ErrExtraBits{1'b0}}, dmin});
  end

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    stop_x_d = stop_x_q;
    stop_y_d = stop_y_q;
    err_d    = err_q;
    inc_s_d  = inc_s_q;
    inc_d_d  = inc_d_q;
    maj_x_d  = maj_x_q;
    busy_d   = busy_q;
    if (is_start) begin
      cur_x_d  = sx0;
      cur_y_d  = sy0;
      stop_x_d = sx1;
      stop_y_d = sy1;
      err_d    = (ext_min <<< 1) - ext_maj;
      inc_s_d  = ext_min <<< 1;
      inc_d_d  = (ext_min - ext_maj) <<< 1;
      maj_x_d  = maj_x_s;
      busy_d   = maj_x_s ? (sx0 != sx1) : (sy0 != sy1);
    end else if (busy_q) begin
      err_d = err_q + (err_q[E-1] ? inc_s_q : inc_d_q);
      if (maj_x_q) begin
        if (!err_q[E-1]) begin
          cur_y_d = (cur_y_q < stop_y_q) ? cur_y_q + W'(1) : cur_y_q - W'(1);
        end
        cur_x_d = cur_x_q + W'(1);
        busy_d  = (cur_x_d != stop_x_q);
      end else begin
        if (!err_q[E-1]) begin
          cur_x_d = (cur_x_q > stop_x_q) ? cur_x_q - W'(1) : cur_x_q + W'(1);
        end
        cur_y_d = cur_y_q + W'(1);
        busy_d  = (cur_y_d != stop_y_q);
      end
    end
  end

  assign res_valid_o = is_start || busy_q;
  assign res_x_o     = cur_x_d;
  assign res_y_o     = cur_y_d;
  assign res_last_o  = !busy_d;
  assign busy_o      = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      stop_x_q <= '0;
      stop_y_q <= '0;
      err_q    <= '0;
      inc_s_q  <= '0;
      inc_d_q  <= '0;
      maj_x_q  <= 1'b0;
      busy_q   <= 1'b0;
    end else if (fire_i) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      stop_x_q <= stop_x_d;
      stop_y_q <= stop_y_d;
      err_q    <= err_d;
      inc_s_q  <= inc_s_d;
      inc_d_q  <= inc_d_d;
      maj_x_q  <= maj_x_d;
      busy_q   <= busy_d;
    end
  end

endmodule

>>> src/line_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// Line pixel rasterizer
// Bresenham line rasterizer with registered command input and pixel output.
// ----------------------------------------------------------------------------
// A start item loads two endpoints and yields the first pixel of the line; each
// advance item yields the next pixel, and the final pixel is flagged with
// last_pixel. An advance while no line is active is consumed and yields nothing.
// The block takes one item per clock and delivers one pixel per clock while the
// pixel output is not stalled. An item lands in the input register when it is
// accepted, and its pixel is loaded into the result register once the result
// register is free; the add, compare and increment of the error term lie
// combinationally between the two registers.
module line_pixel_rasterizer import lpr_pkg::*; #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpr_cmd_if.sink   cmd_i,
  lpr_pix_if.source pix_o
);

  `include "line_pixel_rasterizer_assert.svh"

  logic                  in_valid_q, in_valid_d;
  logic                  in_cmd_q;
  logic [COORD_BITS-1:0] in_x0_q, in_y0_q, in_x1_q, in_y1_q;
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic                  out_last_q;

  logic                  accept, out_free, fire;
  logic                  res_valid, res_last, busy;
  logic [COORD_BITS-1:0] res_x, res_y;

  assign out_free    = !out_valid_q || pix_o.ready;
  assign fire        = in_valid_q && out_free;
  assign cmd_i.ready = !in_valid_q || out_free;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_free ? (fire && res_valid) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_cmd_q <= cmd_i.cmd;
      in_x0_q  <= cmd_i.x_start;
      in_y0_q  <= cmd_i.y_start;
      in_x1_q  <= cmd_i.x_end;
      in_y1_q  <= cmd_i.y_end;
    end
    if (fire && res_valid) begin
      out_x_q    <= res_x;
      out_y_q    <= res_y;
      out_last_q <= res_last;
    end
  end

  lpr_engine #(
    .COORD_BITS(COORD_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .cmd_i      (in_cmd_q),
    .x_start_i  (in_x0_q),
    .y_start_i  (in_y0_q),
    .x_end_i    (in_x1_q),
    .y_end_i    (in_y1_q),
    .res_valid_o(res_valid),
    .res_x_o    (res_x),
    .res_y_o    (res_y),
    .res_last_o (res_last),
    .busy_o     (busy)
  );

  assign pix_o.valid      = out_valid_q;
  assign pix_o.pixel_x    = out_x_q;
  assign pix_o.pixel_y    = out_y_q;
  assign pix_o.last_pixel = out_last_q;

  `LPR_ASSERT_NXT(a_start_emits, fire && (lpr_cmd_e'(in_cmd_q) == CMD_START), out_valid_q)
  `LPR_ASSERT_NXT(a_last_goes_idle, fire && res_valid && res_last, !busy)
  `LPR_ASSERT_NXT(a_blocked_item_holds, in_valid_q && !out_free, in_valid_q)
  `LPR_ASSERT_IMP(a_advance_idle_no_result,
                  fire && !busy && (lpr_cmd_e'(in_cmd_q) == CMD_ADVANCE), !res_valid)

endmodule
